@@ hdl/blfa_pkg.sv @@
// ----------------------------------------------------------------------------
// blfa_pkg
// Shared constants, types and helpers for the blob labeling and feature
// accumulator.
// ----------------------------------------------------------------------------
package blfa_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_LABELS = 64;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int IDX_W  = $clog2(MAX_LABELS);
    localparam int LBL_W  = 7;
    localparam int CNT_W  = 7;
    localparam int PIX_W  = 8;
    localparam int CFG_IW = 8;

    localparam int AREA_W  = 21;
    localparam int SUM_W   = 30;
    localparam int PERIM_W = 23;

    localparam logic [LBL_W-1:0] NO_LABEL = 7'd127;

    localparam logic [CFG_IW-1:0] CFG_THR_LOW  = 8'd0;
    localparam logic [CFG_IW-1:0] CFG_THR_HIGH = 8'd1;

    // One pixel after classification.
    typedef struct packed {
        logic             obj;
        logic             in_range;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             row_end;
        logic             image_end;
    } t_item;

    // Per-blob accumulator entry.
    typedef struct packed {
        logic [AREA_W-1:0]  area;
        logic [SUM_W-1:0]   sum_x;
        logic [SUM_W-1:0]   sum_y;
        logic [PERIM_W-1:0] perim;
    } t_acc;

    typedef struct packed {
        logic               blob_valid;
        logic [AREA_W-1:0]  area;
        logic [SUM_W-1:0]   sum_x;
        logic [SUM_W-1:0]   sum_y;
        logic [PERIM_W-1:0] perim;
        logic               overflow;
        logic               last;
    } t_result;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_LREQ,
        ST_LRD,
        ST_RRD,
        ST_DEC,
        ST_MG_A,
        ST_MG_B,
        ST_SWR,
        ST_SWW,
        ST_PREQ,
        ST_PIX,
        ST_LWR,
        ST_POST,
        ST_EREQ,
        ST_ECHK
    } t_state;

    // Saturating add; operands are zero-extended to the widest field.
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b,
                                                 input logic [SUM_W-1:0] lim);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, lim}) ? lim : s[SUM_W-1:0];
    endfunction

    function automatic t_acc acc_add(input t_acc a, input t_acc b);
        t_acc r;
        r.area  = AREA_W'(sat_add(SUM_W'(a.area), SUM_W'(b.area),
                                  SUM_W'({AREA_W{1'b1}})));
        r.sum_x = sat_add(a.sum_x, b.sum_x, {SUM_W{1'b1}});
        r.sum_y = sat_add(a.sum_y, b.sum_y, {SUM_W{1'b1}});
        r.perim = PERIM_W'(sat_add(SUM_W'(a.perim), SUM_W'(b.perim),
                                   SUM_W'({PERIM_W{1'b1}})));
        return r;
    endfunction

endpackage

@@ hdl/blfa_front.sv @@
// ----------------------------------------------------------------------------
// blfa_front
// Accepts pixels, tracks column and row, applies the threshold window and
// queues classified pixels for the labeling engine.
// ----------------------------------------------------------------------------
module blfa_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [blfa_pkg::PIX_W-1:0] i_pixel_value,
    input  logic                     i_inside_mask,
    input  logic                     i_row_end,
    input  logic                     i_image_end,
    input  logic                     i_cfg_valid,
    input  logic [blfa_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [blfa_pkg::PIX_W-1:0] i_cfg_data,
    input  logic                     i_pop,
    output logic                     o_q_valid,
    output blfa_pkg::t_item          o_q_item
);
    import blfa_pkg::*;

    logic [PIX_W-1:0] r_thr_low;
    logic [PIX_W-1:0] r_thr_high;
    logic [COL_W:0]   r_col;
    logic [ROW_W:0]   r_row;
    t_item            r_buf [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;

    logic  push;
    logic  pop;
    logic  in_range;
    t_item item;

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign pop       = i_pop && (r_cnt != 2'd0);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_buf[r_rd];

    assign in_range = i_inside_mask && (r_col < (COL_W+1)'(MAX_WIDTH))
                      && (r_row < (ROW_W+1)'(MAX_HEIGHT));

    always_comb begin
        item.in_range  = in_range;
        item.obj       = in_range && (i_pixel_value >= r_thr_low)
                         && (i_pixel_value <= r_thr_high);
        item.col       = r_col[COL_W-1:0];
        item.row       = r_row[ROW_W-1:0];
        item.row_end   = i_row_end;
        item.image_end = i_image_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_low  <= '0;
            r_thr_high <= PIX_W'(128);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_THR_LOW) begin
                r_thr_low <= i_cfg_data;
            end else if (i_cfg_index == CFG_THR_HIGH) begin
                r_thr_high <= i_cfg_data;
            end
        end
    end

    // Counters stop at their limits; the image end restarts both.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (push) begin
            if (i_image_end) begin
                r_col <= '0;
                r_row <= '0;
            end else if (i_row_end) begin
                r_col <= '0;
                if (r_row < (ROW_W+1)'(MAX_HEIGHT)) begin
                    r_row <= r_row + 1'b1;
                end
            end else if (r_col < (COL_W+1)'(MAX_WIDTH)) begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ hdl/blfa_back.sv @@
// ----------------------------------------------------------------------------
// blfa_back
// Labeling engine: line store, label roots, per-blob accumulators, merges,
// result emission and the clearing pass.
// ----------------------------------------------------------------------------
module blfa_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  blfa_pkg::t_item   i_q_item,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output blfa_pkg::t_result o_result
);
    import blfa_pkg::*;

    logic [LBL_W-1:0] line_mem [MAX_WIDTH];
    logic [IDX_W-1:0] root_mem [MAX_LABELS];
    t_acc             acc_mem  [MAX_LABELS];

    logic [LBL_W-1:0] line_q;
    logic [IDX_W-1:0] root_q;
    t_acc             acc_q;

    t_state           r_state;
    t_state           n_state;
    t_item            r_item;
    logic [LBL_W-1:0] r_run;
    logic [LBL_W-1:0] r_ar;
    logic [CNT_W-1:0] r_used;
    logic             r_ovf;
    logic [IDX_W-1:0] r_tgt;
    t_acc             r_inc;
    logic [CNT_W-1:0] r_i;
    logic [COL_W-1:0] r_clr;
    t_acc             r_pend;
    logic             r_have;
    logic             r_ovalid;
    logic             n_ovalid;
    t_result          r_res;

    logic             line_we;
    logic [COL_W-1:0] line_addr;
    logic [LBL_W-1:0] line_wdata;
    logic             root_we;
    logic [IDX_W-1:0] root_raddr;
    logic [IDX_W-1:0] root_waddr;
    logic [IDX_W-1:0] root_wdata;
    logic             acc_we;
    logic [IDX_W-1:0] acc_raddr;
    logic [IDX_W-1:0] acc_waddr;
    t_acc             acc_wdata;
    t_acc             new_acc;
    t_acc             pix_inc;
    t_acc             dec_inc;
    t_acc             acc_sum;
    logic             out_free;
    logic             out_load;
    logic             hit;
    logic             run_nl;
    logic             ar_nl;
    logic [LBL_W-1:0] above_root;

    assign out_free = !r_ovalid || !i_stall;
    assign o_valid  = r_ovalid;
    assign o_result = r_res;
    assign o_pop    = (r_state == ST_IDLE) && i_q_valid;
    assign run_nl   = (r_run == NO_LABEL);
    assign ar_nl    = (r_ar == NO_LABEL);
    assign acc_sum  = acc_add(acc_q, r_inc);
    assign hit      = (root_q == r_i[IDX_W-1:0]) && (acc_q.area != '0);
    assign above_root = (line_q < LBL_W'(r_used)) ? LBL_W'(root_q) : NO_LABEL;

    // A result is loaded into the output register at the final step of the
    // sweep or when a newer blob pushes out the pending one.
    assign out_load = ((r_state == ST_EREQ) && (r_i == r_used) && out_free)
                      || ((r_state == ST_ECHK) && hit && r_have && out_free);
    assign n_ovalid = out_load || (r_ovalid && i_stall);

    always_comb begin
        pix_inc.area  = AREA_W'(1);
        pix_inc.sum_x = SUM_W'(r_item.col);
        pix_inc.sum_y = SUM_W'(r_item.row);
        pix_inc.perim = '0;
        new_acc       = pix_inc;
        new_acc.perim = PERIM_W'(2);
        // Increment chosen at the decision step: the pixel itself for an
        // object pixel, plus the boundary edges it closes.
        dec_inc       = r_item.obj ? pix_inc : '0;
        dec_inc.perim = PERIM_W'(1);
        if (!run_nl && !ar_nl) begin
            dec_inc.perim = r_item.obj ? PERIM_W'(0) : PERIM_W'(2);
        end
    end

    // Memories: one write port, one registered read port each.
    always_ff @(posedge i_clk) begin
        if (line_we) begin
            line_mem[line_addr] <= line_wdata;
        end
        line_q <= line_mem[line_addr];
    end

    always_ff @(posedge i_clk) begin
        if (root_we) begin
            root_mem[root_waddr] <= root_wdata;
        end
        root_q <= root_mem[root_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        acc_q <= acc_mem[acc_raddr];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLR: begin
                if (r_clr == COL_W'(MAX_WIDTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = i_q_item.in_range ? ST_LREQ : ST_POST;
                end
            end
            ST_LREQ: n_state = ST_LRD;
            ST_LRD:  n_state = ST_RRD;
            ST_RRD:  n_state = ST_DEC;
            ST_DEC: begin
                if (r_item.obj) begin
                    if (!run_nl && !ar_nl && (r_ar != r_run)) begin
                        n_state = ST_MG_A;
                    end else if (!run_nl || !ar_nl) begin
                        n_state = ST_PREQ;
                    end else begin
                        n_state = ST_LWR;
                    end
                end else begin
                    n_state = (!run_nl || !ar_nl) ? ST_PREQ : ST_LWR;
                end
            end
            ST_MG_A: n_state = ST_MG_B;
            ST_MG_B: n_state = ST_SWR;
            ST_SWR:  n_state = ST_SWW;
            ST_SWW: begin
                n_state = (r_i + 1'b1 == r_used) ? ST_PREQ : ST_SWR;
            end
            ST_PREQ: n_state = ST_PIX;
            ST_PIX:  n_state = ST_LWR;
            ST_LWR:  n_state = ST_POST;
            ST_POST: begin
                n_state = r_item.image_end ? ST_EREQ : ST_IDLE;
            end
            ST_EREQ: begin
                if (r_i == r_used) begin
                    if (out_free) begin
                        n_state = ST_CLR;
                    end
                end else begin
                    n_state = ST_ECHK;
                end
            end
            ST_ECHK: begin
                if (!(hit && r_have && !out_free)) begin
                    n_state = ST_EREQ;
                end
            end
            default: n_state = ST_CLR;
        endcase
    end

    // Memory controls.
    always_comb begin
        line_we    = 1'b0;
        line_addr  = r_item.col;
        line_wdata = r_run;
        root_we    = 1'b0;
        root_raddr = line_q[IDX_W-1:0];
        root_waddr = r_used[IDX_W-1:0];
        root_wdata = r_used[IDX_W-1:0];
        acc_we     = 1'b0;
        acc_raddr  = r_tgt;
        acc_waddr  = r_tgt;
        acc_wdata  = acc_sum;
        unique case (r_state)
            ST_CLR: begin
                line_we    = 1'b1;
                line_addr  = r_clr;
                line_wdata = NO_LABEL;
            end
            ST_DEC: begin
                acc_raddr = r_ar[IDX_W-1:0];
                if (r_item.obj && run_nl && ar_nl
                    && (r_used < CNT_W'(MAX_LABELS))) begin
                    root_we   = 1'b1;
                    acc_we    = 1'b1;
                    acc_waddr = r_used[IDX_W-1:0];
                    acc_wdata = new_acc;
                end
            end
            ST_MG_A: begin
                acc_raddr = r_run[IDX_W-1:0];
                acc_we    = 1'b1;
                acc_waddr = r_ar[IDX_W-1:0];
                acc_wdata = '0;
            end
            ST_MG_B: begin
                acc_we    = 1'b1;
                acc_waddr = r_run[IDX_W-1:0];
            end
            ST_SWR: begin
                root_raddr = r_i[IDX_W-1:0];
            end
            ST_SWW: begin
                root_raddr = r_i[IDX_W-1:0];
                root_waddr = r_i[IDX_W-1:0];
                root_wdata = r_run[IDX_W-1:0];
                root_we    = (root_q == r_ar[IDX_W-1:0]);
            end
            ST_PIX: begin
                acc_we = 1'b1;
            end
            ST_LWR: begin
                line_we = 1'b1;
            end
            ST_EREQ, ST_ECHK: begin
                root_raddr = r_i[IDX_W-1:0];
                acc_raddr  = r_i[IDX_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_run    <= NO_LABEL;
            r_used   <= '0;
            r_ovf    <= 1'b0;
            r_have   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
            case (r_state)
                ST_CLR: begin
                    r_clr <= r_clr + 1'b1;
                end
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_item <= i_q_item;
                        if (!i_q_item.in_range) begin
                            r_run <= NO_LABEL;
                        end
                    end
                end
                ST_RRD: begin
                    r_ar <= above_root;
                end
                ST_DEC: begin
                    r_inc <= dec_inc;
                    if (r_item.obj) begin
                        if (!run_nl) begin
                            r_tgt <= r_run[IDX_W-1:0];
                        end else if (!ar_nl) begin
                            r_run <= r_ar;
                            r_tgt <= r_ar[IDX_W-1:0];
                        end else if (r_used < CNT_W'(MAX_LABELS)) begin
                            r_run  <= LBL_W'(r_used);
                            r_used <= r_used + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end else if (!run_nl) begin
                        r_tgt <= r_run[IDX_W-1:0];
                        r_run <= NO_LABEL;
                    end else begin
                        r_tgt <= r_ar[IDX_W-1:0];
                    end
                end
                ST_MG_A: begin
                    r_inc <= acc_q;
                end
                ST_MG_B: begin
                    r_inc <= pix_inc;
                    r_tgt <= r_run[IDX_W-1:0];
                    r_i   <= '0;
                end
                ST_SWW: begin
                    r_i <= r_i + 1'b1;
                end
                ST_POST: begin
                    if (r_item.row_end || r_item.image_end) begin
                        r_run <= NO_LABEL;
                    end
                    r_i    <= '0;
                    r_have <= 1'b0;
                end
                ST_EREQ: begin
                    if ((r_i == r_used) && out_free) begin
                        r_res.blob_valid <= r_have;
                        r_res.area       <= r_have ? r_pend.area : '0;
                        r_res.sum_x      <= r_have ? r_pend.sum_x : '0;
                        r_res.sum_y      <= r_have ? r_pend.sum_y : '0;
                        r_res.perim      <= r_have ? r_pend.perim : '0;
                        r_res.overflow   <= r_ovf;
                        r_res.last       <= 1'b1;
                        r_clr            <= '0;
                        r_used           <= '0;
                        r_ovf            <= 1'b0;
                    end
                end
                ST_ECHK: begin
                    if (hit) begin
                        if (!r_have || out_free) begin
                            r_pend <= acc_q;
                            r_have <= 1'b1;
                            r_i    <= r_i + 1'b1;
                        end
                        if (r_have && out_free) begin
                            r_res.blob_valid <= 1'b1;
                            r_res.area       <= r_pend.area;
                            r_res.sum_x      <= r_pend.sum_x;
                            r_res.sum_y      <= r_pend.sum_y;
                            r_res.perim      <= r_pend.perim;
                            r_res.overflow   <= r_ovf;
                            r_res.last       <= 1'b0;
                        end
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ hdl/blob_labeling_feature_accumulator_top.sv @@
// ----------------------------------------------------------------------------
// blob_labeling_feature_accumulator_top
// Single-pass connected component labeling with per-blob area, centroid sums
// and boundary edge count.
// ----------------------------------------------------------------------------
// A pixel inside the mask goes through the labeling engine in steps (queue pop, line
// store read, root read, decision, accumulator read-modify-write, line store write);
// a pixel outside the mask or past the size limits goes from pop straight to post.
// A merge adds a root redirect sweep over the labels in use. At image end the results
// leave in a sweep over the labels in use, then a clearing pass over all MAX_WIDTH
// (1024) entries clears the line store. Reset starts it too; pixels queue meanwhile.
// ----------------------------------------------------------------------------
module blob_labeling_feature_accumulator_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Pixel channel.
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [blfa_pkg::PIX_W-1:0]         i_pixel_value,
    input  logic                               i_inside_mask,
    input  logic                               i_row_end,
    input  logic                               i_image_end,
    // Result channel.
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_blob_valid,
    output logic [blfa_pkg::AREA_W-1:0]        o_blob_area,
    output logic [blfa_pkg::SUM_W-1:0]         o_blob_sum_x,
    output logic [blfa_pkg::SUM_W-1:0]         o_blob_sum_y,
    output logic [blfa_pkg::PERIM_W-1:0]       o_blob_perimeter,
    output logic                               o_label_overflow,
    output logic                               o_last_result,
    // Configuration write channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [blfa_pkg::CFG_IW-1:0]        i_cfg_index,
    input  logic [blfa_pkg::PIX_W-1:0]         i_cfg_data
);
    import blfa_pkg::*;

    logic    q_valid;
    t_item   q_item;
    logic    pop;
    t_result result;

    // Configuration transfers are always taken; the thresholds live in the
    // front end next to the comparators.
    assign o_cfg_ready = 1'b1;

    // The front end classifies each pixel and holds up to two in its queue,
    // so pixel transfers continue while the engine works on earlier ones.
    blfa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel_value (i_pixel_value),
        .i_inside_mask (i_inside_mask),
        .i_row_end     (i_row_end),
        .i_image_end   (i_image_end),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pop         (pop),
        .o_q_valid     (q_valid),
        .o_q_item      (q_item)
    );

    // The engine labels runs, merges blobs, accumulates features and drives
    // a registered result port.
    blfa_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_result  (result)
    );

    assign o_blob_valid     = result.blob_valid;
    assign o_blob_area      = result.area;
    assign o_blob_sum_x     = result.sum_x;
    assign o_blob_sum_y     = result.sum_y;
    assign o_blob_perimeter = result.perim;
    assign o_label_overflow = result.overflow;
    assign o_last_result    = result.last;

endmodule
